FILE: rtl/clv_pkg.sv
// Shared types and constants for the configuration text lexer and checker.
package clv_pkg;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SP     = 8'h20;

    localparam logic [2:0] KIND_WORD  = 3'd0;
    localparam logic [2:0] KIND_OPEN  = 3'd1;
    localparam logic [2:0] KIND_CLOSE = 3'd2;
    localparam logic [2:0] KIND_SEMI  = 3'd3;
    localparam logic [2:0] KIND_VERD  = 3'd4;

    localparam logic [2:0] PREV_START = 3'd0;
    localparam logic [2:0] PREV_WORD  = 3'd1;
    localparam logic [2:0] PREV_OPEN  = 3'd2;
    localparam logic [2:0] PREV_CLOSE = 3'd3;
    localparam logic [2:0] PREV_SEMI  = 3'd4;

    localparam logic [2:0] VERD_OK        = 3'd0;
    localparam logic [2:0] VERD_BAD_TRANS = 3'd1;
    localparam logic [2:0] VERD_UNMATCHED = 3'd2;
    localparam logic [2:0] VERD_UNCLOSED  = 3'd3;
    localparam logic [2:0] VERD_OPEN_QUOT = 3'd4;
    localparam logic [2:0] VERD_OVERFLOW  = 3'd5;

    localparam int RESQ_DEPTH     = 4;
    localparam int RESQ_PTR_BITS  = 2;
    localparam int RESQ_CNT_BITS  = 3;

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_WORD = 5'b00010,
        M_DQ   = 5'b00100,
        M_SQ   = 5'b01000,
        M_CMT  = 5'b10000
    } lex_mode_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [2:0]  verdict;
        logic [7:0]  nest_depth;
        logic [31:0] start_offset;
        logic [15:0] token_length;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } wr_t;

endpackage

FILE: rtl/clv_lexer.sv
// Front end: byte lexer, grammar check and nesting depth tracking.
module clv_lexer #(
    parameter int DEPTH_BITS  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  clv_pkg::item_t item,
    output clv_pkg::wr_t   wr
);

    localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX   = '1;

    clv_pkg::lex_mode_t       mode_reg, mode_next;
    logic [2:0]               prev_reg, prev_next;
    logic [DEPTH_BITS-1:0]    depth_reg, depth_next;
    logic [2:0]               err_code_reg, err_code_next;
    logic                     err_seen_reg, err_seen_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   tstart_reg, tstart_next;
    logic [15:0]              tlen_reg, tlen_next;

    function automatic logic [2:0] gram_code(logic [2:0] kind, logic [2:0] prev,
                                             logic [DEPTH_BITS-1:0] dep);
        logic [2:0] code;
        code = clv_pkg::VERD_OK;
        unique case (kind)
            clv_pkg::KIND_SEMI:
                if (prev != clv_pkg::PREV_WORD) code = clv_pkg::VERD_BAD_TRANS;
            clv_pkg::KIND_OPEN:
                if (prev != clv_pkg::PREV_WORD) code = clv_pkg::VERD_BAD_TRANS;
                else if (dep == DEPTH_MAX) code = clv_pkg::VERD_OVERFLOW;
            clv_pkg::KIND_CLOSE:
                if (!(prev inside {clv_pkg::PREV_SEMI, clv_pkg::PREV_CLOSE,
                                   clv_pkg::PREV_OPEN}))
                    code = clv_pkg::VERD_BAD_TRANS;
                else if (dep == '0) code = clv_pkg::VERD_UNMATCHED;
            default:
                code = clv_pkg::VERD_OK;
        endcase
        return code;
    endfunction

    function automatic logic [DEPTH_BITS-1:0] gram_depth(logic [2:0] kind,
                                                         logic [2:0] code,
                                                         logic [DEPTH_BITS-1:0] dep);
        logic [DEPTH_BITS-1:0] d;
        d = dep;
        if (code == clv_pkg::VERD_OK) begin
            if (kind == clv_pkg::KIND_OPEN) d = dep + 1'b1;
            else if (kind == clv_pkg::KIND_CLOSE) d = dep - 1'b1;
        end
        return d;
    endfunction

    function automatic logic [7:0] depth_out(logic [DEPTH_BITS-1:0] dep);
        logic [7:0] v;
        if (dep > DEPTH_BITS'(255)) v = 8'hFF;
        else v = 8'(dep);
        return v;
    endfunction

    function automatic logic [31:0] offset_out(logic [OFFSET_BITS-1:0] p);
        logic [31:0] v;
        if (p > OFFSET_BITS'(32'hFFFF_FFFF)) v = 32'hFFFF_FFFF;
        else v = 32'(p);
        return v;
    endfunction

    always_comb
    begin
        logic [7:0]            c;
        logic                  is_ws, is_open, is_close, is_semi, is_punct;
        logic                  is_text, is_eof, do_idle, quote_err;
        logic                  w_emit, p_emit;
        logic [2:0]            w_code, p_code, p_kind, pk, ec, verd;
        logic [DEPTH_BITS-1:0] dep;
        logic                  es;
        logic [15:0]           tl_inc, w_len;
        logic [OFFSET_BITS-1:0] w_start;
        clv_pkg::result_t      r_w, r_p;

        c        = item.text_byte;
        is_ws    = (c == clv_pkg::CH_SP) || (c == clv_pkg::CH_TAB) ||
                   (c == clv_pkg::CH_LF) || (c == clv_pkg::CH_CR);
        is_open  = (c == clv_pkg::CH_LBRACE);
        is_close = (c == clv_pkg::CH_RBRACE);
        is_semi  = (c == clv_pkg::CH_SEMI);
        is_punct = is_open || is_close || is_semi;
        p_kind   = is_open ? clv_pkg::KIND_OPEN :
                   is_close ? clv_pkg::KIND_CLOSE : clv_pkg::KIND_SEMI;

        is_text   = accept && !item.req_type && !err_seen_reg;
        is_eof    = accept && item.req_type;
        do_idle   = 1'b0;
        quote_err = 1'b0;
        w_emit    = 1'b0;
        p_emit    = 1'b0;
        w_code    = clv_pkg::VERD_OK;
        p_code    = clv_pkg::VERD_OK;
        verd      = clv_pkg::VERD_OK;
        tl_inc    = (tlen_reg == 16'hFFFF) ? tlen_reg : tlen_reg + 16'd1;
        w_len     = tlen_reg;
        w_start   = tstart_reg;

        mode_next     = mode_reg;
        tstart_next   = tstart_reg;
        tlen_next     = tlen_reg;
        pos_next      = pos_reg;

        if (is_text) begin
            pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
            unique case (mode_reg) inside
                clv_pkg::M_IDLE: do_idle = 1'b1;
                clv_pkg::M_WORD:
                    if (is_ws || is_punct) begin
                        w_emit    = 1'b1;
                        mode_next = clv_pkg::M_IDLE;
                        do_idle   = 1'b1;
                    end else begin
                        tlen_next = tl_inc;
                    end
                clv_pkg::M_DQ, clv_pkg::M_SQ:
                begin
                    tlen_next = tl_inc;
                    if ((mode_reg == clv_pkg::M_DQ && c == clv_pkg::CH_DQ) ||
                        (mode_reg == clv_pkg::M_SQ && c == clv_pkg::CH_SQ)) begin
                        mode_next = clv_pkg::M_IDLE;
                        w_emit    = 1'b1;
                        w_len     = tl_inc;
                    end
                end
                clv_pkg::M_CMT:
                    if (c == clv_pkg::CH_LF || c == clv_pkg::CH_CR)
                        mode_next = clv_pkg::M_IDLE;
                default: mode_next = mode_reg;
            endcase
        end else if (is_eof && !err_seen_reg) begin
            if (mode_reg == clv_pkg::M_DQ || mode_reg == clv_pkg::M_SQ) quote_err = 1'b1;
            else if (mode_reg == clv_pkg::M_WORD) w_emit = 1'b1;
        end

        pk  = prev_reg;
        dep = depth_reg;
        es  = err_seen_reg;
        ec  = err_code_reg;

        if (w_emit) begin
            w_code = gram_code(clv_pkg::KIND_WORD, pk, dep);
            dep    = gram_depth(clv_pkg::KIND_WORD, w_code, dep);
            if (w_code == clv_pkg::VERD_OK) pk = clv_pkg::PREV_WORD;
            else begin
                es = 1'b1;
                ec = w_code;
            end
        end
        r_w.token_kind   = clv_pkg::KIND_WORD;
        r_w.verdict      = w_code;
        r_w.nest_depth   = depth_out(dep);
        r_w.start_offset = offset_out(w_start);
        r_w.token_length = w_len;
        r_w.last_of_run  = 1'b0;

        if (do_idle && !es) begin
            if (is_punct) begin
                p_emit = 1'b1;
                p_code = gram_code(p_kind, pk, dep);
                dep    = gram_depth(p_kind, p_code, dep);
                if (p_code == clv_pkg::VERD_OK) pk = 3'(p_kind + 3'd1);
                else begin
                    es = 1'b1;
                    ec = p_code;
                end
            end else if (c == clv_pkg::CH_HASH) begin
                mode_next = clv_pkg::M_CMT;
            end else if (!is_ws) begin
                mode_next   = (c == clv_pkg::CH_DQ) ? clv_pkg::M_DQ :
                              (c == clv_pkg::CH_SQ) ? clv_pkg::M_SQ : clv_pkg::M_WORD;
                tstart_next = pos_reg;
                tlen_next   = 16'd1;
            end
        end

        if (is_eof) begin
            p_emit = 1'b1;
            if (quote_err) begin
                es = 1'b1;
                ec = clv_pkg::VERD_OPEN_QUOT;
            end else if (!es) begin
                if (!(pk inside {clv_pkg::PREV_SEMI, clv_pkg::PREV_CLOSE,
                                 clv_pkg::PREV_START}))
                    ec = clv_pkg::VERD_BAD_TRANS;
                else if (dep != '0) ec = clv_pkg::VERD_UNCLOSED;
                else ec = clv_pkg::VERD_OK;
                es = (ec != clv_pkg::VERD_OK);
            end
            verd = es ? ec : clv_pkg::VERD_OK;
        end

        r_p.token_kind   = is_eof ? clv_pkg::KIND_VERD : p_kind;
        r_p.verdict      = is_eof ? verd : p_code;
        r_p.nest_depth   = depth_out(dep);
        r_p.start_offset = offset_out(pos_reg);
        r_p.token_length = is_eof ? 16'd0 : 16'd1;
        r_p.last_of_run  = 1'b1;

        wr.count = {1'b0, w_emit} + {1'b0, p_emit};
        wr.r1    = r_p;
        if (w_emit && p_emit) wr.r0 = r_w;
        else if (w_emit) begin
            wr.r0             = r_w;
            wr.r0.last_of_run = 1'b1;
        end else wr.r0 = r_p;

        prev_next     = pk;
        depth_next    = dep;
        err_seen_next = es;
        err_code_next = ec;

        if (is_eof) begin
            mode_next     = clv_pkg::M_IDLE;
            prev_next     = clv_pkg::PREV_START;
            depth_next    = '0;
            err_code_next = clv_pkg::VERD_OK;
            err_seen_next = 1'b0;
            pos_next      = '0;
            tstart_next   = '0;
            tlen_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= clv_pkg::M_IDLE;
            prev_reg     <= clv_pkg::PREV_START;
            depth_reg    <= '0;
            err_code_reg <= clv_pkg::VERD_OK;
            err_seen_reg <= 1'b0;
            pos_reg      <= '0;
            tstart_reg   <= '0;
            tlen_reg     <= '0;
        end else begin
            mode_reg     <= mode_next;
            prev_reg     <= prev_next;
            depth_reg    <= depth_next;
            err_code_reg <= err_code_next;
            err_seen_reg <= err_seen_next;
            pos_reg      <= pos_next;
            tstart_reg   <= tstart_next;
            tlen_reg     <= tlen_next;
        end
    end

`ifndef SYNTHESIS
    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.req_type |=> mode_reg == clv_pkg::M_IDLE && depth_reg == '0 &&
                                    !err_seen_reg && pos_reg == '0)
        else $error("state not cleared after end of input");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_seen_reg && !(accept && item.req_type) |=> err_seen_reg && $stable(pos_reg))
        else $error("latched error lost or position moved");
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        wr.count == 2'd2 |-> wr.r0.token_kind == clv_pkg::KIND_WORD &&
                             wr.r1.token_kind != clv_pkg::KIND_WORD && wr.r1.last_of_run)
        else $error("bad order of two results from one byte");
`endif

endmodule

FILE: rtl/clv_resq.sv
// Back end: result queue taking up to two transfers per cycle, one out.
module clv_resq (
    input  logic             clk,
    input  logic             rst_n,
    input  clv_pkg::wr_t     wr,
    input  logic             pop,
    output clv_pkg::result_t result,
    output logic             empty,
    output logic             full
);

    clv_pkg::result_t                  slot_reg [clv_pkg::RESQ_DEPTH];
    logic [clv_pkg::RESQ_PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [clv_pkg::RESQ_PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [clv_pkg::RESQ_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                              pop_ok;

    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg > clv_pkg::RESQ_CNT_BITS'(clv_pkg::RESQ_DEPTH - 2));
    assign pop_ok = pop && !empty;
    assign result = slot_reg[rptr_reg];

    assign wptr_next = wptr_reg + clv_pkg::RESQ_PTR_BITS'(wr.count);
    assign rptr_next = rptr_reg + clv_pkg::RESQ_PTR_BITS'(pop_ok);
    assign cnt_next  = cnt_reg + clv_pkg::RESQ_CNT_BITS'(wr.count)
                       - clv_pkg::RESQ_CNT_BITS'(pop_ok);

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0) slot_reg[wptr_reg] <= wr.r0;
        if (wr.count == 2'd2) slot_reg[wptr_reg + 1'b1] <= wr.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= clv_pkg::RESQ_CNT_BITS'(clv_pkg::RESQ_DEPTH))
        else $error("result queue overrun");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop_ok && wr.count == 2'd0 |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count wrong after pop");
`endif

endmodule

FILE: rtl/config_token_lexer_validator.sv
// Top level: configuration text lexer and syntax checker with result queue.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------
//  input     | push / full      | item   (req_type, text_byte)
//  result    | pop / empty      | result (token_kind .. last_of_run)
//
//  One input transfer per cycle unless full; each byte or end-of-input item
//  is lexed and checked in the cycle it is taken and gives up to two results.
//  Results leave a four-entry queue at one per cycle, so bytes that make two
//  tokens throttle input to the output drain rate.
//  full rises when fewer than two queue entries are free.
//  Reset is asynchronous; it clears lexer state and empties the queue.
module config_token_lexer_validator #(
    parameter int DEPTH_BITS  = 8,
    parameter int OFFSET_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  clv_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output clv_pkg::result_t result
);

    logic         accept;
    clv_pkg::wr_t wr;

    assign accept = push && !full;

    clv_lexer #(
        .DEPTH_BITS  (DEPTH_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lexer (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .wr     (wr)
    );

    clv_resq u_resq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (wr),
        .pop    (pop),
        .result (result),
        .empty  (empty),
        .full   (full)
    );

endmodule
